### rtl/hktb_pkg.sv
package hktb_pkg;

    localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
    localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
    localparam logic [7:0] MOD_ALT_MASK   = 8'h44;

    localparam logic [7:0] ESC_CODE   = 8'h1B;
    localparam logic [7:0] CSI_CODE   = 8'h5B;
    localparam logic [7:0] CR_CODE    = 8'h0D;
    localparam logic [7:0] DEL_CODE   = 8'h7F;
    localparam logic [7:0] TAB_CODE   = 8'h09;
    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] TILDE_CODE = 8'h7E;

    localparam logic [7:0] KEY_LETTER_FIRST = 8'h04;
    localparam logic [7:0] KEY_LETTER_LAST  = 8'h1D;
    localparam logic [7:0] KEY_DIGIT_FIRST  = 8'h1E;
    localparam logic [7:0] KEY_DIGIT_LAST   = 8'h27;
    localparam logic [7:0] KEY_SYM_FIRST    = 8'h2D;
    localparam logic [7:0] KEY_SYM_LAST     = 8'h38;
    localparam logic [7:0] KEY_ENTER        = 8'h28;
    localparam logic [7:0] KEY_ESCAPE       = 8'h29;
    localparam logic [7:0] KEY_BACKSPACE    = 8'h2A;
    localparam logic [7:0] KEY_TAB          = 8'h2B;
    localparam logic [7:0] KEY_SPACE        = 8'h2C;
    localparam logic [7:0] KEY_UP           = 8'h52;
    localparam logic [7:0] KEY_DOWN         = 8'h51;
    localparam logic [7:0] KEY_RIGHT        = 8'h4F;
    localparam logic [7:0] KEY_LEFT         = 8'h50;
    localparam logic [7:0] KEY_DELETE       = 8'h4C;
    localparam logic [7:0] KEY_HOME         = 8'h4A;
    localparam logic [7:0] KEY_END          = 8'h4D;
    localparam logic [7:0] KEY_PAGE_UP      = 8'h4B;
    localparam logic [7:0] KEY_PAGE_DOWN    = 8'h4E;

    localparam logic [15:0] STUCK_LIMIT_RESET = 16'd150;
    localparam logic [15:0] REPEAT_RUN_MAX    = 16'hFFFF;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_code;
    } key_event_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } term_byte_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] seq_bytes;
    } seq_t;

    function automatic seq_t put_printable(input logic alt, input logic [7:0] c);
        seq_t s;
        s = '0;
        if (alt)
        begin
            s.len          = 3'd2;
            s.seq_bytes[0] = ESC_CODE;
            s.seq_bytes[1] = c;
        end
        else
        begin
            s.len          = 3'd1;
            s.seq_bytes[0] = c;
        end
        return s;
    endfunction

    function automatic seq_t put_seq(input logic [7:0] b1, input logic [7:0] b2);
        seq_t s;
        s = '0;
        s.seq_bytes[0] = ESC_CODE;
        s.seq_bytes[1] = CSI_CODE;
        s.seq_bytes[2] = b1;
        s.seq_bytes[3] = b2;
        s.len          = (b2 != 8'h00) ? 3'd4 : 3'd3;
        return s;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] off, input logic shift);
        logic [7:0] c;
        case (off)
            4'd0:    c = shift ? 8'h21 : 8'h31;
            4'd1:    c = shift ? 8'h40 : 8'h32;
            4'd2:    c = shift ? 8'h23 : 8'h33;
            4'd3:    c = shift ? 8'h24 : 8'h34;
            4'd4:    c = shift ? 8'h25 : 8'h35;
            4'd5:    c = shift ? 8'h5E : 8'h36;
            4'd6:    c = shift ? 8'h26 : 8'h37;
            4'd7:    c = shift ? 8'h2A : 8'h38;
            4'd8:    c = shift ? 8'h28 : 8'h39;
            4'd9:    c = shift ? 8'h29 : 8'h30;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // A zero result marks the unmapped non-US hash key.
    function automatic logic [7:0] sym_char(input logic [3:0] off, input logic shift);
        logic [7:0] c;
        case (off)
            4'd0:    c = shift ? 8'h5F : 8'h2D;
            4'd1:    c = shift ? 8'h2B : 8'h3D;
            4'd2:    c = shift ? 8'h7B : 8'h5B;
            4'd3:    c = shift ? 8'h7D : 8'h5D;
            4'd4:    c = shift ? 8'h7C : 8'h5C;
            4'd6:    c = shift ? 8'h3A : 8'h3B;
            4'd7:    c = shift ? 8'h22 : 8'h27;
            4'd8:    c = shift ? 8'h7E : 8'h60;
            4'd9:    c = shift ? 8'h3C : 8'h2C;
            4'd10:   c = shift ? 8'h3E : 8'h2E;
            4'd11:   c = shift ? 8'h3F : 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic seq_t translate(input key_event_t ev);
        seq_t       s;
        logic       ctrl;
        logic       shift;
        logic       alt;
        logic [7:0] off;
        logic [7:0] c;
        s     = '0;
        ctrl  = |(ev.modifier_bits & MOD_CTRL_MASK);
        shift = |(ev.modifier_bits & MOD_SHIFT_MASK);
        alt   = |(ev.modifier_bits & MOD_ALT_MASK);
        off   = 8'h00;
        c     = 8'h00;
        if (ev.modifier_bits == 8'h00 && ev.key_code == 8'h00)
        begin
            s = '0;
        end
        else if (ev.key_code >= KEY_LETTER_FIRST && ev.key_code <= KEY_LETTER_LAST)
        begin
            off = ev.key_code - KEY_LETTER_FIRST;
            if (ctrl)
            begin
                s.len          = 3'd1;
                s.seq_bytes[0] = off + 8'd1;
            end
            else
            begin
                s = put_printable(alt, (shift ? 8'h41 : 8'h61) + off);
            end
        end
        else if (ev.key_code >= KEY_DIGIT_FIRST && ev.key_code <= KEY_DIGIT_LAST)
        begin
            off = ev.key_code - KEY_DIGIT_FIRST;
            s   = put_printable(alt, digit_char(off[3:0], shift));
        end
        else if (ev.key_code >= KEY_SYM_FIRST && ev.key_code <= KEY_SYM_LAST)
        begin
            off = ev.key_code - KEY_SYM_FIRST;
            c   = sym_char(off[3:0], shift);
            if (c != 8'h00)
            begin
                s = put_printable(alt, c);
            end
        end
        else
        begin
            case (ev.key_code)
                KEY_ENTER:
                begin
                    s.len          = 3'd1;
                    s.seq_bytes[0] = CR_CODE;
                end
                KEY_ESCAPE:
                begin
                    s.len          = 3'd1;
                    s.seq_bytes[0] = ESC_CODE;
                end
                KEY_BACKSPACE:
                begin
                    s.len          = 3'd1;
                    s.seq_bytes[0] = DEL_CODE;
                end
                KEY_TAB:
                begin
                    s.len          = 3'd1;
                    s.seq_bytes[0] = TAB_CODE;
                end
                KEY_SPACE:     s = put_printable(alt, SPACE_CODE);
                KEY_UP:        s = put_seq(8'h41, 8'h00);
                KEY_DOWN:      s = put_seq(8'h42, 8'h00);
                KEY_RIGHT:     s = put_seq(8'h43, 8'h00);
                KEY_LEFT:      s = put_seq(8'h44, 8'h00);
                KEY_DELETE:    s = put_seq(8'h33, TILDE_CODE);
                KEY_HOME:      s = put_seq(8'h48, 8'h00);
                KEY_END:       s = put_seq(8'h46, 8'h00);
                KEY_PAGE_UP:   s = put_seq(8'h35, TILDE_CODE);
                KEY_PAGE_DOWN: s = put_seq(8'h36, TILDE_CODE);
                default:       s = '0;
            endcase
        end
        return s;
    endfunction

endpackage

### rtl/hktb_front.sv
module hktb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_stall,
    input  hktb_pkg::key_event_t key_event,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output hktb_pkg::seq_t      q_push_data
);
    import hktb_pkg::*;

    logic [15:0] stuck_limit_reg;
    logic [7:0]  prev_modifier_reg;
    logic [7:0]  prev_key_reg;
    logic [15:0] repeat_run_reg;
    logic [15:0] repeat_run_next;
    logic        accept;
    logic        same;
    logic        suppress;
    seq_t        seq;

    assign key_stall = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = key_valid && !key_stall;

    assign same = (key_event.modifier_bits == prev_modifier_reg) &&
                  (key_event.key_code == prev_key_reg);
    assign repeat_run_next = (repeat_run_reg == REPEAT_RUN_MAX) ? repeat_run_reg
                                                                : repeat_run_reg + 16'd1;
    assign suppress = same && (repeat_run_next >= stuck_limit_reg);

    assign seq         = translate(key_event);
    assign q_push      = accept && !suppress && (seq.len != 3'd0);
    assign q_push_data = seq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuck_limit_reg <= STUCK_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stuck_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_modifier_reg <= 8'h00;
            prev_key_reg      <= 8'h00;
            repeat_run_reg    <= 16'h0000;
        end
        else if (accept)
        begin
            if (same)
            begin
                repeat_run_reg <= repeat_run_next;
            end
            else
            begin
                prev_modifier_reg <= key_event.modifier_bits;
                prev_key_reg      <= key_event.key_code;
                repeat_run_reg    <= 16'h0000;
            end
        end
    end

endmodule

### rtl/hktb_queue.sv
module hktb_queue #(
    parameter int DEPTH = hktb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hktb_pkg::seq_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output hktb_pkg::seq_t pop_data
);
    import hktb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seq_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/hktb_back.sv
module hktb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  hktb_pkg::seq_t       q_data,
    output logic                 q_pop,
    output logic                 byte_valid,
    input  logic                 byte_stall,
    output hktb_pkg::term_byte_t byte_item
);
    import hktb_pkg::*;

    seq_t       seq_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       byte_valid_reg;
    term_byte_t byte_item_reg;
    logic       out_free;
    logic       advance;
    logic       at_last;

    assign out_free = !byte_valid_reg || !byte_stall;
    assign advance  = busy_reg && out_free;
    assign at_last  = ({1'b0, idx_reg} + 3'd1) == seq_reg.len;
    assign q_pop    = q_valid && (!busy_reg || (advance && at_last));

    assign byte_valid = byte_valid_reg;
    assign byte_item  = byte_item_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            seq_reg <= q_data;
        end
        if (out_free)
        begin
            byte_item_reg.out_byte  <= seq_reg.seq_bytes[idx_reg];
            byte_item_reg.last_byte <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            idx_reg        <= 2'd0;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                byte_valid_reg <= busy_reg;
            end
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (advance && at_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

### rtl/hid_key_to_terminal_bytes.sv
// The first byte of an event passes the request queue, the sequence register and the
// output byte register before it is valid. The serializer sends an event's 1 to 4 bytes
// and takes the next request with its last byte; silent events push no request.
// A short request queue between the classifier and the serializer absorbs bursts.
// Reset is asynchronous and active low: it empties the queue, clears the repeat
// tracker and loads stuck_limit with 150.
module hid_key_to_terminal_bytes #(
    parameter int QUEUE_DEPTH = hktb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 key_valid,
    output logic                 key_stall,
    input  hktb_pkg::key_event_t key_event,
    output logic                 byte_valid,
    input  logic                 byte_stall,
    output hktb_pkg::term_byte_t byte_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    import hktb_pkg::*;

    logic q_full;
    logic q_push;
    seq_t q_push_data;
    logic q_pop;
    logic q_valid;
    seq_t q_pop_data;

    hktb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_valid   (key_valid),
        .key_stall   (key_stall),
        .key_event   (key_event),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    hktb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    hktb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request popped from an empty queue");

    a_zero_event_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid && !key_stall && key_event.modifier_bits == 8'h00 &&
         key_event.key_code == 8'h00) |-> !q_push)
        else $error("all-zero event produced a request");

    a_request_length: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_push_data.len != 3'd0 && q_push_data.len <= 3'd4))
        else $error("request with an invalid byte count");
`endif

endmodule
